@@ src/stok_pkg.sv @@
// stok_pkg: shared types, constants and helper functions for the source tokenizer.
// Used by every module in src; depends on nothing.
package stok_pkg;

  localparam int OFFSET_BITS_DEF   = 24;
  localparam int POSITION_BITS_DEF = 16;
  localparam int LENGTH_BITS       = 16;
  localparam int KW_BITS           = 48;
  localparam int KW_CHARS          = 6;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_INT     = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_PENDING = 3'd5,
    MODE_HALTED  = 3'd6
  } scan_mode_t;

  localparam logic [5:0] KIND_EOF    = 6'd0;
  localparam logic [5:0] KIND_IDENT  = 6'd1;
  localparam logic [5:0] KIND_STRING = 6'd2;
  localparam logic [5:0] KIND_INT    = 6'd3;
  localparam logic [5:0] KIND_ERROR  = 6'd39;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL  = 3'd1;
  localparam logic [2:0] ERR_AMP      = 3'd2;
  localparam logic [2:0] ERR_BAR      = 3'd3;
  localparam logic [2:0] ERR_UNTERM   = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL = 8'h0a;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [2:0]  error_code;
    logic [7:0]  offending_byte;
    logic        closing_token;
  } out_item_t;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       is_ws;
    logic       is_nl;
    logic       is_letter;
    logic       is_digit;
    logic       is_quote;
    logic       is_bslash;
    logic       is_opstart;
    logic [5:0] single;
  } cls_t;

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    unique case (c)
      8'h7b: single_kind = 6'd4;
      8'h7d: single_kind = 6'd5;
      8'h28: single_kind = 6'd6;
      8'h29: single_kind = 6'd7;
      8'h2c: single_kind = 6'd8;
      8'h3b: single_kind = 6'd9;
      8'h3a: single_kind = 6'd10;
      8'h2b: single_kind = 6'd11;
      8'h2a: single_kind = 6'd13;
      8'h2f: single_kind = 6'd14;
      default: single_kind = 6'd0;
    endcase
  endfunction

  // second byte, two-byte kind, one-byte kind (zero = lone & or |)
  function automatic logic [19:0] op_pair(input logic [7:0] op);
    unique case (op)
      8'h2d: op_pair = {8'h3e, 6'd25, 6'd12};
      8'h3d: op_pair = {8'h3d, 6'd16, 6'd15};
      8'h21: op_pair = {8'h3d, 6'd17, 6'd22};
      8'h3c: op_pair = {8'h3d, 6'd19, 6'd18};
      8'h3e: op_pair = {8'h3d, 6'd21, 6'd20};
      8'h26: op_pair = {8'h26, 6'd23, 6'd0};
      8'h7c: op_pair = {8'h7c, 6'd24, 6'd0};
      default: op_pair = 20'd0;
    endcase
  endfunction

  function automatic logic [5:0] word_kind(input logic [47:0] kb, input logic [15:0] n);
    logic [5:0] k;
    k = KIND_IDENT;
    if (n == 16'd2 && kb == 48'h666e) k = 6'd26;
    if (n == 16'd3 && kb == 48'h6c6574) k = 6'd27;
    if (n == 16'd3 && kb == 48'h6d7574) k = 6'd28;
    if (n == 16'd6 && kb == 48'h72657475726e) k = 6'd29;
    if (n == 16'd2 && kb == 48'h6966) k = 6'd30;
    if (n == 16'd4 && kb == 48'h656c7365) k = 6'd31;
    if (n == 16'd5 && kb == 48'h7768696c65) k = 6'd32;
    if (n == 16'd4 && kb == 48'h74727565) k = 6'd33;
    if (n == 16'd5 && kb == 48'h66616c7365) k = 6'd34;
    if (n == 16'd3 && kb == 48'h696e74) k = 6'd35;
    if (n == 16'd6 && kb == 48'h737472696e67) k = 6'd36;
    if (n == 16'd4 && kb == 48'h626f6f6c) k = 6'd37;
    if (n == 16'd5 && kb == 48'h7072696e74) k = 6'd38;
    return k;
  endfunction

endpackage

@@ src/source_tokenizer.sv @@
// source_tokenizer: top level; streaming lexer, one source byte per item.
// An accepted item is registered in the front queue before it reaches the scanner,
// and its tokens are registered in the token queue before they reach the output.
// Throughput: one byte per cycle while the four-entry token queue has room for three
// more tokens. Reset (rst, synchronous) empties both queues and returns the scanner
// to line 1, column 1, offset 0. Depends on stok_pkg, stok_front, stok_back.
module source_tokenizer #(
  parameter int OFFSET_BITS   = stok_pkg::OFFSET_BITS_DEF,
  parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  stok_pkg::in_item_t  in_item,
  input  logic                in_valid,
  output logic                in_stall,
  output stok_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_stall
);
  // front: classify bytes into a two-entry queue
  stok_pkg::cls_t q_item;
  logic           q_valid, q_pop;

  stok_front u_front (
    .clk, .rst, .in_item, .in_valid, .in_stall,
    .q_item, .q_valid, .q_pop
  );

  // back: scan state and token queue
  stok_back #(.OFFSET_BITS(OFFSET_BITS), .POSITION_BITS(POSITION_BITS)) u_back (
    .clk, .rst, .q_item, .q_valid, .q_pop,
    .out_item, .out_valid, .out_stall
  );

  // a byte is only consumed when the front has one
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("back end consumed from an empty queue");
  // an end-of-file token always closes the source
  a_eof_closes: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_item.token_kind == stok_pkg::KIND_EOF) |-> out_item.closing_token)
    else $error("eof token without closing flag");
  // an error token carries an error code
  a_err_code: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_item.token_kind == stok_pkg::KIND_ERROR) |->
      (out_item.error_code != stok_pkg::ERR_NONE))
    else $error("error token without code");
endmodule

@@ src/stok_front.sv @@
// stok_front: accepts source bytes, classifies them and queues them for the back end.
// Depends on stok_pkg.
module stok_front (
  input  logic               clk,
  input  logic               rst,
  input  stok_pkg::in_item_t in_item,
  input  logic               in_valid,
  output logic               in_stall,
  output stok_pkg::cls_t     q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  localparam int DEPTH = 2;

  stok_pkg::cls_t slots [DEPTH];
  logic           rd_ptr, wr_ptr;
  logic [1:0]     count;
  stok_pkg::cls_t cls;
  logic           push;
  logic [7:0]     c;

  assign c = in_item.source_byte;
  always_comb begin
    cls.ch         = c;
    cls.fin        = in_item.final_byte;
    cls.is_nl      = (c == stok_pkg::CH_NL);
    cls.is_ws      = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    cls.is_letter  = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    cls.is_digit   = (c >= 8'h30 && c <= 8'h39);
    cls.is_quote   = (c == stok_pkg::CH_QUOTE);
    cls.is_bslash  = (c == stok_pkg::CH_BSLASH);
    cls.is_opstart = (stok_pkg::op_pair(c) != 20'd0);
    cls.single     = stok_pkg::single_kind(c);
  end

  assign in_stall = (count == 2'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

@@ src/stok_back.sv @@
// stok_back: scan state machine; turns classified bytes into up to three tokens,
// buffered in an output queue. Depends on stok_pkg.
module stok_back #(
  parameter int OFFSET_BITS   = stok_pkg::OFFSET_BITS_DEF,
  parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  stok_pkg::cls_t      q_item,
  input  logic                q_valid,
  output logic                q_pop,
  output stok_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_stall
);
  localparam int OQ = 4;
  localparam logic [OFFSET_BITS-1:0]   OFF_MAX = '1;
  localparam logic [OFFSET_BITS-1:0]   OFF_ONE = OFFSET_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  stok_pkg::scan_mode_t mode, mode_next;
  logic [7:0]  pend, pend_next;
  logic [OFFSET_BITS-1:0]   off, off_next, toff, toff_next;
  logic [POSITION_BITS-1:0] line, line_next, col, col_next;
  logic [POSITION_BITS-1:0] tline, tline_next, tcol, tcol_next;
  logic [15:0] tcnt, tcnt_next;
  logic [47:0] kb, kb_next;

  stok_pkg::out_item_t res [3];
  logic [1:0] nres;

  stok_pkg::out_item_t oq [OQ];
  logic [1:0] oq_rd, oq_wr;
  logic [2:0] oq_cnt;
  logic       pop_out, step;

  assign step  = q_valid && (oq_cnt <= 3'(OQ - 3));
  assign q_pop = step;
  assign out_valid = (oq_cnt != 3'd0);
  assign out_item  = oq[oq_rd];
  assign pop_out   = out_valid && !out_stall;

  function automatic stok_pkg::out_item_t mk(
    input logic [5:0] k, input logic [OFFSET_BITS-1:0] o, input logic [15:0] len,
    input logic [POSITION_BITS-1:0] l, input logic [POSITION_BITS-1:0] cc,
    input logic [2:0] e, input logic [7:0] b, input logic cl);
    stok_pkg::out_item_t r;
    r.token_kind     = k;
    r.start_offset   = 24'(o);
    r.token_length   = len;
    r.start_line     = 16'(l);
    r.start_column   = 16'(cc);
    r.error_code     = e;
    r.offending_byte = b;
    r.closing_token  = cl;
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic taken, newline, adv, absorb_b, begin_b, err;
    logic [7:0] second;
    logic [5:0] two, one;
    c = q_item.ch;
    mode_next = mode; pend_next = pend;
    off_next = off; line_next = line; col_next = col;
    toff_next = toff; tline_next = tline; tcol_next = tcol;
    tcnt_next = tcnt; kb_next = kb;
    nres = 2'd0;
    res[0] = '0; res[1] = '0; res[2] = '0;
    taken = 1'b0; newline = 1'b0; adv = 1'b0; absorb_b = 1'b0; begin_b = 1'b0;
    err = 1'b0;
    {second, two, one} = stok_pkg::op_pair(pend);
    if (mode == stok_pkg::MODE_HALTED) begin
      taken = 1'b1;
      err = 1'b1;
    end else begin
      unique case (mode)
        stok_pkg::MODE_IDENT: begin
          if (q_item.is_letter || q_item.is_digit) begin
            if (tcnt < 16'd6) kb_next = {kb[39:0], c};
            absorb_b = 1'b1; taken = 1'b1;
          end else begin
            res[nres] = mk(stok_pkg::word_kind(kb, tcnt), toff, tcnt, tline, tcol,
                           stok_pkg::ERR_NONE, 8'd0, 1'b0);
            nres = nres + 2'd1;
            mode_next = stok_pkg::MODE_IDLE;
          end
        end
        stok_pkg::MODE_INT: begin
          if (q_item.is_digit) begin
            absorb_b = 1'b1; taken = 1'b1;
          end else begin
            res[nres] = mk(stok_pkg::KIND_INT, toff, tcnt, tline, tcol,
                           stok_pkg::ERR_NONE, 8'd0, 1'b0);
            nres = nres + 2'd1;
            mode_next = stok_pkg::MODE_IDLE;
          end
        end
        stok_pkg::MODE_STRING: begin
          absorb_b = 1'b1; taken = 1'b1;
          if (q_item.is_bslash) mode_next = stok_pkg::MODE_ESCAPE;
          else if (q_item.is_quote) begin
            res[nres] = mk(stok_pkg::KIND_STRING, toff,
                           (tcnt == 16'hffff) ? tcnt : tcnt + 16'd1, tline, tcol,
                           stok_pkg::ERR_NONE, 8'd0, 1'b0);
            nres = nres + 2'd1;
            mode_next = stok_pkg::MODE_IDLE;
          end
        end
        stok_pkg::MODE_ESCAPE: begin
          absorb_b = 1'b1; taken = 1'b1;
          mode_next = stok_pkg::MODE_STRING;
        end
        stok_pkg::MODE_PENDING: begin
          if (two != 6'd0 && c == second) begin
            absorb_b = 1'b1; taken = 1'b1;
            res[nres] = mk(two, toff, 16'd2, tline, tcol, stok_pkg::ERR_NONE, 8'd0, 1'b0);
            nres = nres + 2'd1;
            mode_next = stok_pkg::MODE_IDLE;
          end else if (one != 6'd0) begin
            res[nres] = mk(one, toff, 16'd1, tline, tcol, stok_pkg::ERR_NONE, 8'd0, 1'b0);
            nres = nres + 2'd1;
            mode_next = stok_pkg::MODE_IDLE;
          end else begin
            // lone & or |: the following byte is swallowed
            res[nres] = mk(stok_pkg::KIND_ERROR, toff, 16'd1, tline, tcol,
                           (pend == 8'h7c) ? stok_pkg::ERR_BAR : stok_pkg::ERR_AMP,
                           pend, 1'b1);
            nres = nres + 2'd1;
            err = 1'b1; taken = 1'b1;
          end
        end
        default: mode_next = stok_pkg::MODE_IDLE;
      endcase

      if (!taken) begin
        if (q_item.is_ws) begin
          adv = 1'b1; newline = q_item.is_nl;
        end else if (q_item.single != 6'd0) begin
          res[nres] = mk(q_item.single, off, 16'd1, line, col,
                         stok_pkg::ERR_NONE, 8'd0, 1'b0);
          nres = nres + 2'd1;
          adv = 1'b1;
        end else if (q_item.is_opstart) begin
          pend_next = c; begin_b = 1'b1; mode_next = stok_pkg::MODE_PENDING;
        end else if (q_item.is_quote) begin
          begin_b = 1'b1; mode_next = stok_pkg::MODE_STRING;
        end else if (q_item.is_digit) begin
          begin_b = 1'b1; mode_next = stok_pkg::MODE_INT;
        end else if (q_item.is_letter) begin
          kb_next = {40'd0, c}; begin_b = 1'b1; mode_next = stok_pkg::MODE_IDENT;
        end else begin
          toff_next = off; tline_next = line; tcol_next = col;
          res[nres] = mk(stok_pkg::KIND_ERROR, off, 16'd1, line, col,
                         stok_pkg::ERR_ILLEGAL, c, 1'b1);
          nres = nres + 2'd1;
          err = 1'b1;
        end
      end
      if (absorb_b) tcnt_next = (tcnt == 16'hffff) ? tcnt : tcnt + 16'd1;
      if (begin_b) begin
        toff_next = off; tline_next = line; tcol_next = col; tcnt_next = 16'd1;
      end
      if (absorb_b || begin_b || adv) begin
        off_next = (off == OFF_MAX) ? off : off + OFF_ONE;
        if (newline) begin
          line_next = (line == POS_MAX) ? line : line + POS_ONE;
          col_next = POS_ONE;
        end else begin
          col_next = (col == POS_MAX) ? col : col + POS_ONE;
        end
      end
      if (err) mode_next = stok_pkg::MODE_HALTED;
    end

    if (q_item.fin) begin
      if (!err) begin
        unique case (mode_next)
          stok_pkg::MODE_IDENT: begin
            res[nres] = mk(stok_pkg::word_kind(kb_next, tcnt_next), toff_next, tcnt_next,
                           tline_next, tcol_next, stok_pkg::ERR_NONE, 8'd0, 1'b0);
            nres = nres + 2'd1;
          end
          stok_pkg::MODE_INT: begin
            res[nres] = mk(stok_pkg::KIND_INT, toff_next, tcnt_next, tline_next, tcol_next,
                           stok_pkg::ERR_NONE, 8'd0, 1'b0);
            nres = nres + 2'd1;
          end
          stok_pkg::MODE_STRING, stok_pkg::MODE_ESCAPE: begin
            res[nres] = mk(stok_pkg::KIND_ERROR, toff_next, 16'd1, tline_next, tcol_next,
                           stok_pkg::ERR_UNTERM, stok_pkg::CH_QUOTE, 1'b1);
            nres = nres + 2'd1;
            err = 1'b1;
          end
          stok_pkg::MODE_PENDING: begin
            {second, two, one} = stok_pkg::op_pair(pend_next);
            if (one != 6'd0) begin
              res[nres] = mk(one, toff_next, 16'd1, tline_next, tcol_next,
                             stok_pkg::ERR_NONE, 8'd0, 1'b0);
            end else begin
              res[nres] = mk(stok_pkg::KIND_ERROR, toff_next, 16'd1, tline_next, tcol_next,
                             (pend_next == 8'h7c) ? stok_pkg::ERR_BAR : stok_pkg::ERR_AMP,
                             pend_next, 1'b1);
              err = 1'b1;
            end
            nres = nres + 2'd1;
          end
          default: ;
        endcase
        if (!err) begin
          res[nres] = mk(stok_pkg::KIND_EOF, '0, 16'd0, '0, '0, stok_pkg::ERR_NONE,
                         8'd0, 1'b1);
          nres = nres + 2'd1;
        end
      end
      mode_next = stok_pkg::MODE_IDLE; pend_next = 8'd0;
      off_next = '0; line_next = POS_ONE; col_next = POS_ONE;
      toff_next = '0; tline_next = POS_ONE; tcol_next = POS_ONE;
      tcnt_next = 16'd0; kb_next = 48'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (nres > 2'd0) oq[oq_wr] <= res[0];
      if (nres > 2'd1) oq[oq_wr + 2'd1] <= res[1];
      if (nres > 2'd2) oq[oq_wr + 2'd2] <= res[2];
    end
    if (rst) begin
      mode <= stok_pkg::MODE_IDLE; pend <= 8'd0;
      off <= '0; line <= POS_ONE; col <= POS_ONE;
      toff <= '0; tline <= POS_ONE; tcol <= POS_ONE;
      tcnt <= 16'd0; kb <= 48'd0;
      oq_rd <= 2'd0; oq_wr <= 2'd0; oq_cnt <= 3'd0;
    end else begin
      if (step) begin
        mode <= mode_next; pend <= pend_next;
        off <= off_next; line <= line_next; col <= col_next;
        toff <= toff_next; tline <= tline_next; tcol <= tcol_next;
        tcnt <= tcnt_next; kb <= kb_next;
        oq_wr <= oq_wr + nres;
      end
      if (pop_out) oq_rd <= oq_rd + 2'd1;
      oq_cnt <= oq_cnt + (step ? 3'(nres) : 3'd0) - 3'(pop_out);
    end
  end
endmodule
